// ===== hw/rtl/ehr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehr_pkg: shared types and constants of the ECG heart rate detector
// Register indexes, reset values of the registers and the rate history type.
// ----------------------------------------------------------------------------
package ehr_pkg;

	localparam int HIST_DEPTH     = 5;
	localparam int HIST_IDX_BITS  = $clog2(HIST_DEPTH);
	localparam int MED_RANK       = HIST_DEPTH / 2;
	localparam int RATE_BITS      = 16;
	localparam int TICK_BITS      = 32;
	localparam int TPS_BITS       = 16;
	localparam int THR_BITS       = 36;
	localparam int PEAK_BITS      = 37;
	localparam int DIV_BITS       = 32;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 36;

	typedef logic [HIST_DEPTH-1:0][RATE_BITS-1:0] hist_t;
	typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

	localparam cfg_index_t REG_TICKS_PER_SAMPLE   = 3'd0;
	localparam cfg_index_t REG_MIN_INTERVAL_TICKS = 3'd1;
	localparam cfg_index_t REG_TIMEOUT_TICKS      = 3'd2;
	localparam cfg_index_t REG_CUBE_THRESHOLD     = 3'd3;
	localparam cfg_index_t REG_RATE_NUMERATOR     = 3'd4;

	localparam logic [TPS_BITS-1:0]  RST_TICKS_PER_SAMPLE   = 16'd3200;
	localparam logic [TICK_BITS-1:0] RST_MIN_INTERVAL_TICKS = 32'd2400000;
	localparam logic [TICK_BITS-1:0] RST_TIMEOUT_TICKS      = 32'd48000000;
	localparam logic [THR_BITS-1:0]  RST_CUBE_THRESHOLD     = 36'd15000;
	localparam logic [TICK_BITS-1:0] RST_RATE_NUMERATOR     = 32'd960000000;

endpackage

// ===== hw/rtl/ehr_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehr_if: stream channels of the heart rate detector
// Sample channel (lead-off mark and sample) and result channel.
// ----------------------------------------------------------------------------
interface ehr_in_if #(
	parameter int SAMPLE_BITS = 12
) ();
	logic                   valid;
	logic                   ready;
	logic                   lead_off;
	logic [SAMPLE_BITS-1:0] sample;

	modport source (output valid, lead_off, sample, input ready);
	modport sink   (input valid, lead_off, sample, output ready);
endinterface

interface ehr_out_if ();
	logic                                  valid;
	logic                                  ready;
	logic                                  beat;
	logic signed [ehr_pkg::PEAK_BITS-1:0]  peak_cube;
	logic        [ehr_pkg::RATE_BITS-1:0]  rate_latest;
	logic        [ehr_pkg::RATE_BITS-1:0]  rate_median;
	logic                                  timed_out;

	modport source (output valid, beat, peak_cube, rate_latest, rate_median, timed_out,
		input ready);
	modport sink   (input valid, beat, peak_cube, rate_latest, rate_median, timed_out,
		output ready);
endinterface

// ===== hw/rtl/ehr_cube.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehr_cube: serial cube of the backward sample difference
// Shift-add multiply, one multiplier bit per cycle: square first, then times
// the magnitude again. Sign applied at the end.
// ----------------------------------------------------------------------------
module ehr_cube #(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [SAMPLE_BITS-1:0]          prev,
	input  logic [SAMPLE_BITS-1:0]          cur,
	output logic                            busy,
	output logic signed [3*SAMPLE_BITS:0]   cube
);

	localparam int PW   = 3 * SAMPLE_BITS;
	localparam int CNTW = $clog2(SAMPLE_BITS);

	logic [SAMPLE_BITS:0]   diff;
	logic [SAMPLE_BITS:0]   diff_abs;
	logic [SAMPLE_BITS-1:0] mag;
	logic [PW-1:0]          sum;
	logic                   last;

	logic [PW-1:0]          mcand_q;
	logic [SAMPLE_BITS-1:0] mplier_q;
	logic [SAMPLE_BITS-1:0] mag_q;
	logic [PW-1:0]          acc_q;
	logic [CNTW-1:0]        cnt_q;
	logic                   phase_q;
	logic                   neg_q;
	logic                   busy_q;
	logic signed [PW:0]     cube_q;

	always_comb begin
		diff     = {1'b0, prev} - {1'b0, cur};
		diff_abs = diff[SAMPLE_BITS] ? (~diff + 1'b1) : diff;
		mag      = diff_abs[SAMPLE_BITS-1:0];
		sum      = acc_q + (mplier_q[0] ? mcand_q : '0);
		last     = (cnt_q == CNTW'(SAMPLE_BITS - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= 1'b0;
			cnt_q   <= '0;
		end else if (start) begin
			busy_q  <= 1'b1;
			phase_q <= 1'b0;
			cnt_q   <= '0;
		end else if (busy_q) begin
			cnt_q <= last ? '0 : cnt_q + 1'b1;
			if (last) begin
				if (!phase_q) begin
					phase_q <= 1'b1;
				end else begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q    <= mag;
			neg_q    <= diff[SAMPLE_BITS];
			mcand_q  <= PW'(mag);
			mplier_q <= mag;
			acc_q    <= '0;
		end else if (busy_q) begin
			if (last && !phase_q) begin
				// square done, multiply it by the magnitude once more
				mcand_q  <= sum;
				mplier_q <= mag_q;
				acc_q    <= '0;
			end else begin
				mcand_q  <= {mcand_q[PW-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[SAMPLE_BITS-1:1]};
				acc_q    <= sum;
			end
			if (last && phase_q) begin
				cube_q <= neg_q ? -$signed({1'b0, sum}) : $signed({1'b0, sum});
			end
		end
	end

	assign busy = busy_q;
	assign cube = cube_q;

endmodule

// ===== hw/rtl/ehr_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehr_div: serial rate divider
// Restoring division, one quotient bit per cycle. Quotient
// saturates to 16 bits; a zero divisor yields all ones and so saturates too.
// ----------------------------------------------------------------------------
module ehr_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [ehr_pkg::DIV_BITS-1:0]        numer,
	input  logic [ehr_pkg::DIV_BITS-1:0]        denom,
	output logic                                busy,
	output logic [ehr_pkg::RATE_BITS-1:0]       rate
);

	localparam int DW   = ehr_pkg::DIV_BITS;
	localparam int RW   = ehr_pkg::RATE_BITS;
	localparam int CNTW = $clog2(DW);

	logic [DW:0]     shifted;
	logic [DW+1:0]   diff;
	logic            ge;
	logic [DW-1:0]   quo_n;

	logic [DW:0]     rem_q;
	logic [DW-1:0]   quo_q;
	logic [DW-1:0]   den_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic [RW-1:0]   rate_q;

	always_comb begin
		shifted = {rem_q[DW-1:0], quo_q[DW-1]};
		diff    = {1'b0, shifted} - {2'b00, den_q};
		ge      = ~diff[DW+1];
		quo_n   = {quo_q[DW-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNTW'(DW - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= numer;
			den_q <= denom;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW:0] : shifted;
			quo_q <= quo_n;
			if (cnt_q == CNTW'(DW - 1)) begin
				rate_q <= (|quo_n[DW-1:RW]) ? '1 : quo_n[RW-1:0];
			end
		end
	end

	assign busy = busy_q;
	assign rate = rate_q;

endmodule

// ===== hw/rtl/ehr_median.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehr_median: median of the rate history
// One candidate entry per cycle; its rank (smaller entries, plus equal ones
// earlier in the history) picks the middle element.
// ----------------------------------------------------------------------------
module ehr_median (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  ehr_pkg::hist_t                  hist,
	output logic                            busy,
	output logic [ehr_pkg::RATE_BITS-1:0]   median
);

	localparam int DEPTH = ehr_pkg::HIST_DEPTH;
	localparam int IW    = ehr_pkg::HIST_IDX_BITS;

	logic [ehr_pkg::RATE_BITS-1:0] cand;
	logic [IW:0]                   rank;

	logic [IW-1:0]                 idx_q;
	logic                          busy_q;
	logic [ehr_pkg::RATE_BITS-1:0] med_q;

	always_comb begin
		cand = hist[idx_q];
		rank = '0;
		for (int j = 0; j < DEPTH; j++) begin
			if ((hist[j] < cand) || ((hist[j] == cand) && (IW'(j) < idx_q))) begin
				rank = rank + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (busy_q) begin
			idx_q <= idx_q + 1'b1;
			if (idx_q == IW'(DEPTH - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && (rank == (IW + 1)'(ehr_pkg::MED_RANK))) begin
			med_q <= cand;
		end
	end

	assign busy   = busy_q;
	assign median = med_q;

endmodule

// ===== hw/rtl/ecg_heart_rate_detector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecg_heart_rate_detector: derivative-threshold QRS detector, median-5 rate
// Cubes the sample difference, runs the interval and beat checks and keeps a
// five-entry rate history whose newest entry and median go out per item.
// ----------------------------------------------------------------------------
// Usage:
//   samples: one request per ECG sample or lead-off mark, valid/ready.
//   results: one request back per sample request, valid/ready.
//   wr_en/wr_index/wr_data: register writes, only while the block is idle.
// Timing:
//   A sample request runs the serial cube and the 32-step serial divider
//   side by side from acceptance, then a state that sees both done, the
//   update state, the serial median with a state that sees it done, and
//   the state that loads the result register. A lead-off request skips
//   the cube and divider.
//   One request is worked on at a time; samples.ready is high when idle and
//   rises the cycle after the result register loads, so a new request is
//   taken only once the last one has been handed to the result register.
// Reset: registers take their default values, history and state clear.
// Stall: the result register holds its request while results.ready is low;
//   the next sample is still taken and worked on, and only its hand-over to
//   the result register waits.
// ----------------------------------------------------------------------------
module ecg_heart_rate_detector #(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	ehr_in_if.sink                               samples,
	ehr_out_if.source                            results,
	input  logic                                 wr_en,
	input  logic [ehr_pkg::CFG_INDEX_BITS-1:0]   wr_index,
	input  logic [ehr_pkg::CFG_DATA_BITS-1:0]    wr_data
);

	localparam int CW   = 3 * SAMPLE_BITS + 1;
	localparam int CMPW = ((CW > ehr_pkg::PEAK_BITS) ? CW : ehr_pkg::PEAK_BITS) + 1;
	localparam int TW   = ehr_pkg::TICK_BITS;
	localparam int RW   = ehr_pkg::RATE_BITS;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_CALC   = 5'b00010,
		ST_UPDATE = 5'b00100,
		ST_MEDIAN = 5'b01000,
		ST_OUT    = 5'b10000
	} state_t;

	state_t state_q;

	// registers
	logic [ehr_pkg::TPS_BITS-1:0] tps_q;
	logic [TW-1:0]                min_q;
	logic [TW-1:0]                tout_q;
	logic [ehr_pkg::THR_BITS-1:0] thr_q;
	logic [TW-1:0]                num_q;

	// detector state
	logic [SAMPLE_BITS-1:0] prev_sample_q;
	logic signed [CW-1:0]   prev_cube_q;
	logic [TW-1:0]          elapsed_q;
	logic [TW-1:0]          stamp_q;
	ehr_pkg::hist_t         hist_q;

	// current item
	logic                   lead_q;
	logic [SAMPLE_BITS-1:0] sample_q;
	logic                   beat_q;
	logic [ehr_pkg::PEAK_BITS-1:0] peak_q;
	logic                   tmo_q;

	// result register
	logic                   out_valid_q;
	logic                   out_beat_q;
	logic [ehr_pkg::PEAK_BITS-1:0] out_peak_q;
	logic [RW-1:0]          out_latest_q;
	logic [RW-1:0]          out_median_q;
	logic                   out_tmo_q;

	logic                   accept;
	logic                   unit_start;
	logic                   cube_busy;
	logic                   div_busy;
	logic                   med_busy;
	logic signed [CW-1:0]   cube;
	logic [RW-1:0]          rate;
	logic [RW-1:0]          median;
	logic                   out_load;

	logic [TW:0]            el_sum;
	logic [TW-1:0]          el_sat;
	logic signed [CMPW-1:0] cube_ext;
	logic signed [CMPW-1:0] thr_ext;
	logic                   past_min;
	logic                   is_timeout;
	logic                   is_cross;
	logic                   is_beat;

	assign accept     = samples.valid && samples.ready;
	assign unit_start = accept && !samples.lead_off;
	assign out_load   = (state_q == ST_OUT) && (!out_valid_q || results.ready);

	ehr_cube #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_cube (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (unit_start),
		.prev   (prev_sample_q),
		.cur    (samples.sample),
		.busy   (cube_busy),
		.cube   (cube)
	);

	// the stamp changes only in the update cycle; the numerator keeps its value while the user writes no register
	ehr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (unit_start),
		.numer  (num_q),
		.denom  (stamp_q),
		.busy   (div_busy),
		.rate   (rate)
	);

	ehr_median u_median (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_UPDATE),
		.hist   (hist_q),
		.busy   (med_busy),
		.median (median)
	);

	always_comb begin
		el_sum     = {1'b0, elapsed_q} + {{(TW + 1 - ehr_pkg::TPS_BITS){1'b0}}, tps_q};
		el_sat     = el_sum[TW] ? '1 : el_sum[TW-1:0];
		cube_ext   = CMPW'(cube);
		thr_ext    = $signed({{(CMPW - ehr_pkg::THR_BITS){1'b0}}, thr_q});
		past_min   = el_sat > min_q;
		is_timeout = past_min && (el_sat >= tout_q);
		is_cross   = past_min && !is_timeout && (cube >= 0) && (prev_cube_q <= 0);
		is_beat    = past_min && !is_timeout && !is_cross && (cube_ext >= thr_ext);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q  <= ehr_pkg::RST_TICKS_PER_SAMPLE;
			min_q  <= ehr_pkg::RST_MIN_INTERVAL_TICKS;
			tout_q <= ehr_pkg::RST_TIMEOUT_TICKS;
			thr_q  <= ehr_pkg::RST_CUBE_THRESHOLD;
			num_q  <= ehr_pkg::RST_RATE_NUMERATOR;
		end else if (wr_en) begin
			unique case (wr_index)
				ehr_pkg::REG_TICKS_PER_SAMPLE:   tps_q  <= wr_data[ehr_pkg::TPS_BITS-1:0];
				ehr_pkg::REG_MIN_INTERVAL_TICKS: min_q  <= wr_data[TW-1:0];
				ehr_pkg::REG_TIMEOUT_TICKS:      tout_q <= wr_data[TW-1:0];
				ehr_pkg::REG_CUBE_THRESHOLD:     thr_q  <= wr_data[ehr_pkg::THR_BITS-1:0];
				ehr_pkg::REG_RATE_NUMERATOR:     num_q  <= wr_data[TW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			prev_sample_q <= '0;
			prev_cube_q   <= '0;
			elapsed_q     <= '0;
			stamp_q       <= '0;
			hist_q        <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= samples.lead_off ? ST_UPDATE : ST_CALC;
					end
				end
				ST_CALC: begin
					if (!cube_busy && !div_busy) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					state_q <= ST_MEDIAN;
					if (lead_q) begin
						hist_q <= {RW'(0), hist_q[ehr_pkg::HIST_DEPTH-1:1]};
					end else begin
						prev_sample_q <= sample_q;
						prev_cube_q   <= cube;
						if (is_timeout || is_beat) begin
							elapsed_q <= '0;
						end else begin
							elapsed_q <= el_sat;
						end
						if (is_cross) begin
							stamp_q <= el_sat;
						end
						if (is_timeout) begin
							hist_q <= '0;
						end else if (is_beat) begin
							hist_q <= {rate, hist_q[ehr_pkg::HIST_DEPTH-1:1]};
						end
					end
				end
				ST_MEDIAN: begin
					if (!med_busy) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lead_q   <= samples.lead_off;
			sample_q <= samples.sample;
		end
		if (state_q == ST_UPDATE) begin
			beat_q <= !lead_q && is_beat;
			tmo_q  <= !lead_q && is_timeout;
			peak_q <= (!lead_q && is_beat) ? cube_ext[ehr_pkg::PEAK_BITS-1:0] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_beat_q   <= beat_q;
			out_peak_q   <= peak_q;
			out_latest_q <= hist_q[ehr_pkg::HIST_DEPTH-1];
			out_median_q <= median;
			out_tmo_q    <= tmo_q;
		end
	end

	assign samples.ready       = (state_q == ST_IDLE);
	assign results.valid       = out_valid_q;
	assign results.beat        = out_beat_q;
	assign results.peak_cube   = $signed(out_peak_q);
	assign results.rate_latest = out_latest_q;
	assign results.rate_median = out_median_q;
	assign results.timed_out   = out_tmo_q;

endmodule

// ===== tb/sv/ecg_heart_rate_detector_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecg_heart_rate_detector_tb: self-checking bench of the ECG heart rate detector
// Drives sample and lead-off requests under random flow control and predicts
// beat, peak cube, timeout and the rate history (newest and median) per request.
// Directed checks first, then rise/fall waveforms under varied register settings.
// ----------------------------------------------------------------------------
module ecg_heart_rate_detector_tb;

	localparam int SAMPLE_W = 12;
	localparam int DRAIN_CYCLES = 64;
	localparam int CYCLE_LIMIT = 1500000;
	localparam logic [ehr_pkg::RATE_BITS-1:0] RATE_CAP = 16'hFFFF;
	localparam logic [ehr_pkg::THR_BITS-1:0] THR_TOP = 36'd68669157375;
	localparam logic [ehr_pkg::TICK_BITS-1:0] TICK_TOP = 32'hFFFFFFFF;

	typedef struct {
		logic                                 beat;
		logic signed [ehr_pkg::PEAK_BITS-1:0] peak_cube;
		logic        [ehr_pkg::RATE_BITS-1:0] rate_latest;
		logic        [ehr_pkg::RATE_BITS-1:0] rate_median;
		logic                                 timed_out;
	} rate_result_t;

	logic clk;
	logic arst_n;
	logic wr_en;
	ehr_pkg::cfg_index_t wr_index;
	logic [ehr_pkg::CFG_DATA_BITS-1:0] wr_data;

	ehr_in_if #(.SAMPLE_BITS(SAMPLE_W)) in_ch ();
	ehr_out_if out_ch ();

	ecg_heart_rate_detector #(.SAMPLE_BITS(SAMPLE_W)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.samples  (in_ch),
		.results  (out_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// register copies
	logic [ehr_pkg::TPS_BITS-1:0]  cfg_tps;
	logic [ehr_pkg::TICK_BITS-1:0] cfg_min;
	logic [ehr_pkg::TICK_BITS-1:0] cfg_timeout;
	logic [ehr_pkg::THR_BITS-1:0]  cfg_thr;
	logic [ehr_pkg::TICK_BITS-1:0] cfg_num;

	// detector state copy
	logic [SAMPLE_W-1:0]           prior_sample;
	longint                        last_cube;
	logic [ehr_pkg::TICK_BITS-1:0] tick_count;
	logic [ehr_pkg::TICK_BITS-1:0] cross_stamp;
	logic [ehr_pkg::RATE_BITS-1:0] rate_hist [ehr_pkg::HIST_DEPTH];

	rate_result_t rate_q [$];
	rate_result_t want;
	int mismatch_count = 0;
	int cycle_count = 0;
	int send_idle_pct = 35;
	int recv_idle_pct = 83;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic void push_hist(input logic [ehr_pkg::RATE_BITS-1:0] r);
		for (int i = 0; i < ehr_pkg::HIST_DEPTH - 1; i++)
			rate_hist[i] = rate_hist[i + 1];
		rate_hist[ehr_pkg::HIST_DEPTH - 1] = r;
	endfunction

	function automatic logic [ehr_pkg::RATE_BITS-1:0] median_of_hist();
		logic [ehr_pkg::RATE_BITS-1:0] v [ehr_pkg::HIST_DEPTH];
		logic [ehr_pkg::RATE_BITS-1:0] t;
		for (int i = 0; i < ehr_pkg::HIST_DEPTH; i++)
			v[i] = rate_hist[i];
		for (int i = 0; i < ehr_pkg::HIST_DEPTH - 1; i++)
			for (int j = 0; j < ehr_pkg::HIST_DEPTH - 1 - i; j++)
				if (v[j] > v[j + 1]) begin
					t = v[j];
					v[j] = v[j + 1];
					v[j + 1] = t;
				end
		return v[ehr_pkg::MED_RANK];
	endfunction

	function automatic rate_result_t predict_rate(input logic lo, input logic [SAMPLE_W-1:0] s);
		rate_result_t r;
		longint diff;
		longint cube;
		logic [ehr_pkg::TICK_BITS:0] sum;
		logic [ehr_pkg::TICK_BITS-1:0] quot;
		r.beat = 1'b0;
		r.peak_cube = '0;
		r.timed_out = 1'b0;
		if (lo) begin
			push_hist('0);
		end else begin
			diff = longint'(prior_sample) - longint'(s);
			cube = diff * diff * diff;
			sum = {1'b0, tick_count}
				+ {{(ehr_pkg::TICK_BITS + 1 - ehr_pkg::TPS_BITS){1'b0}}, cfg_tps};
			tick_count = sum[ehr_pkg::TICK_BITS] ? TICK_TOP : sum[ehr_pkg::TICK_BITS-1:0];
			prior_sample = s;
			if (tick_count > cfg_min) begin
				if (tick_count >= cfg_timeout) begin
					for (int i = 0; i < ehr_pkg::HIST_DEPTH; i++)
						rate_hist[i] = '0;
					tick_count = '0;
					r.timed_out = 1'b1;
				end else if (cube >= 0 && last_cube <= 0) begin
					cross_stamp = tick_count;
				end else if (cube >= longint'(cfg_thr)) begin
					// no crossing seen yet: divider returns all ones
					quot = (cross_stamp == 0) ? (ehr_pkg::TICK_BITS)'(RATE_CAP)
						: cfg_num / cross_stamp;
					push_hist((quot > (ehr_pkg::TICK_BITS)'(RATE_CAP)) ? RATE_CAP
						: quot[ehr_pkg::RATE_BITS-1:0]);
					tick_count = '0;
					r.beat = 1'b1;
					r.peak_cube = cube[ehr_pkg::PEAK_BITS-1:0];
				end
			end
			// crossing test above used the previous cube
			last_cube = cube;
		end
		r.rate_latest = rate_hist[ehr_pkg::HIST_DEPTH - 1];
		r.rate_median = median_of_hist();
		return r;
	endfunction

	function automatic void check_field(input string name, input logic signed [63:0] exp_v,
		input logic signed [63:0] act_v);
		if (act_v !== exp_v) begin
			mismatch_count++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
		end
	endfunction

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (rate_q.size() == 0) begin
				mismatch_count++;
				$display("%0t: result with no request pending, expected none, got rate %0d",
					$time, out_ch.rate_latest);
			end else begin
				want = rate_q.pop_front();
				check_field("beat", 64'(want.beat), 64'(out_ch.beat));
				check_field("peak_cube", 64'(want.peak_cube), 64'(out_ch.peak_cube));
				check_field("rate_latest", 64'(want.rate_latest), 64'(out_ch.rate_latest));
				check_field("rate_median", 64'(want.rate_median), 64'(out_ch.rate_median));
				check_field("timed_out", 64'(want.timed_out), 64'(out_ch.timed_out));
			end
		end
	end

	always @(negedge clk)
		out_ch.ready = ($urandom_range(99) >= recv_idle_pct);

	task automatic send_sample(input logic lo, input logic [SAMPLE_W-1:0] s);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid = 1'b0;
			in_ch.lead_off = 1'($urandom_range(1));
			in_ch.sample = SAMPLE_W'($urandom);
			@(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.lead_off = lo;
		in_ch.sample = s;
		do
			@(posedge clk);
		while (!in_ch.ready);
		rate_q.push_back(predict_rate(lo, s));
	endtask

	// wait for the block to go idle
	task automatic drain_block();
		@(negedge clk);
		in_ch.valid = 1'b0;
		while (rate_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input ehr_pkg::cfg_index_t idx,
		input logic [ehr_pkg::CFG_DATA_BITS-1:0] val);
		@(negedge clk);
		wr_en = 1'b1;
		wr_index = idx;
		wr_data = val;
		@(negedge clk);
		wr_en = 1'b0;
		case (idx)
			ehr_pkg::REG_TICKS_PER_SAMPLE:   cfg_tps = val[ehr_pkg::TPS_BITS-1:0];
			ehr_pkg::REG_MIN_INTERVAL_TICKS: cfg_min = val[ehr_pkg::TICK_BITS-1:0];
			ehr_pkg::REG_TIMEOUT_TICKS:      cfg_timeout = val[ehr_pkg::TICK_BITS-1:0];
			ehr_pkg::REG_CUBE_THRESHOLD:     cfg_thr = val[ehr_pkg::THR_BITS-1:0];
			ehr_pkg::REG_RATE_NUMERATOR:     cfg_num = val[ehr_pkg::TICK_BITS-1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [ehr_pkg::TPS_BITS-1:0] tps,
		input logic [ehr_pkg::TICK_BITS-1:0] min_t,
		input logic [ehr_pkg::TICK_BITS-1:0] tmo, input logic [ehr_pkg::THR_BITS-1:0] thr,
		input logic [ehr_pkg::TICK_BITS-1:0] num);
		drain_block();
		write_reg(ehr_pkg::REG_TICKS_PER_SAMPLE, (ehr_pkg::CFG_DATA_BITS)'(tps));
		write_reg(ehr_pkg::REG_MIN_INTERVAL_TICKS, (ehr_pkg::CFG_DATA_BITS)'(min_t));
		write_reg(ehr_pkg::REG_TIMEOUT_TICKS, (ehr_pkg::CFG_DATA_BITS)'(tmo));
		write_reg(ehr_pkg::REG_CUBE_THRESHOLD, (ehr_pkg::CFG_DATA_BITS)'(thr));
		write_reg(ehr_pkg::REG_RATE_NUMERATOR, (ehr_pkg::CFG_DATA_BITS)'(num));
	endtask

	// reset values: checks never run, cube extremes both ways, lead-off
	task automatic test_default_regs();
		send_sample(1'b0, '0);
		send_sample(1'b0, '1);
		send_sample(1'b0, '0);
		send_sample(1'b1, '1);
	endtask

	// beat before any crossing was stamped
	task automatic test_zero_stamp_beat();
		set_config(16'd1, tick_count + 32'd2, TICK_TOP, ehr_pkg::RST_CUBE_THRESHOLD,
			ehr_pkg::RST_RATE_NUMERATOR);
		send_sample(1'b0, 12'd3000);
		send_sample(1'b0, 12'd2900);
		send_sample(1'b0, 12'd2800);
		send_sample(1'b0, 12'd2700);
	endtask

	// crossing then beat; quotient saturates, then normal, then zero numerator
	task automatic test_rate_saturation();
		set_config(16'd20000, '0, TICK_TOP, 36'd1, TICK_TOP);
		send_sample(1'b0, 12'd100);
		send_sample(1'b0, 12'd200);
		send_sample(1'b0, 12'd150);
		send_sample(1'b0, 12'd100);
		drain_block();
		write_reg(ehr_pkg::REG_RATE_NUMERATOR,
			(ehr_pkg::CFG_DATA_BITS)'(ehr_pkg::RST_RATE_NUMERATOR));
		send_sample(1'b0, 12'd200);
		send_sample(1'b0, 12'd150);
		send_sample(1'b1, 12'd1234);
		send_sample(1'b0, 12'd100);
		drain_block();
		write_reg(ehr_pkg::REG_RATE_NUMERATOR, '0);
		send_sample(1'b0, 12'd200);
		send_sample(1'b0, 12'd150);
		send_sample(1'b0, 12'd100);
	endtask

	task automatic test_timeout_clear();
		set_config('1, '0, '0, ehr_pkg::RST_CUBE_THRESHOLD, ehr_pkg::RST_RATE_NUMERATOR);
		send_sample(1'b0, '1);
		send_sample(1'b0, '0);
		set_config('1, TICK_TOP, TICK_TOP, ehr_pkg::RST_CUBE_THRESHOLD,
			ehr_pkg::RST_RATE_NUMERATOR);
		send_sample(1'b0, 12'd1);
	endtask

	// zero threshold: zero cube after a positive one is a beat; top threshold: none
	task automatic test_threshold_extremes();
		set_config(16'd1, '0, TICK_TOP, '0, ehr_pkg::RST_RATE_NUMERATOR);
		send_sample(1'b0, 12'd50);
		send_sample(1'b0, 12'd40);
		send_sample(1'b0, 12'd40);
		drain_block();
		write_reg(ehr_pkg::REG_CUBE_THRESHOLD, (ehr_pkg::CFG_DATA_BITS)'(THR_TOP));
		send_sample(1'b0, '1);
		send_sample(1'b0, '0);
	endtask

	task automatic test_unknown_index();
		drain_block();
		for (int k = int'(ehr_pkg::REG_RATE_NUMERATOR) + 1; k < 2 ** ehr_pkg::CFG_INDEX_BITS;
			k++)
			write_reg(ehr_pkg::cfg_index_t'(k),
				(ehr_pkg::CFG_DATA_BITS)'({$urandom, $urandom}));
		send_sample(1'b0, 12'd2048);
	endtask

	task automatic random_config();
		logic [ehr_pkg::TPS_BITS-1:0] tps;
		logic [ehr_pkg::TICK_BITS-1:0] tmo;
		logic [ehr_pkg::TICK_BITS-1:0] num;
		tps = (ehr_pkg::TPS_BITS)'($urandom_range(1, 5000));
		if ($urandom_range(9) == 0)
			tmo = TICK_TOP;
		else
			tmo = tps * $urandom_range(6, 40);
		if ($urandom_range(3) == 0)
			num = $urandom;
		else
			num = $urandom_range(1000000, 300000000);
		set_config(tps, tps * $urandom_range(0, 3), tmo,
			(ehr_pkg::THR_BITS)'($urandom_range(0, 150000)), num);
	endtask

	// mostly rise/fall waveforms, some noise and lead-off marks
	task automatic run_random_phase(input int n_items);
		int sent;
		int kind;
		int rise_n;
		int fall_n;
		int lvl;
		sent = 0;
		lvl = int'(prior_sample);
		while (sent < n_items) begin
			kind = $urandom_range(99);
			if (kind < 80) begin
				rise_n = $urandom_range(1, 4);
				fall_n = $urandom_range(2, 5);
				for (int i = 0; i < rise_n + fall_n; i++) begin
					if (i < rise_n)
						lvl += int'($urandom_range(1, 400));
					else
						lvl -= int'($urandom_range(1, 700));
					if (lvl < 0)
						lvl = 0;
					if (lvl > 2 ** SAMPLE_W - 1)
						lvl = 2 ** SAMPLE_W - 1;
					if ($urandom_range(49) == 0)
						send_sample(1'b1, SAMPLE_W'($urandom));
					else
						send_sample(1'b0, SAMPLE_W'(lvl));
					sent++;
				end
			end else if (kind < 93) begin
				lvl = $urandom_range(0, 2 ** SAMPLE_W - 1);
				send_sample(1'b0, SAMPLE_W'(lvl));
				sent++;
			end else begin
				send_sample(1'b1, SAMPLE_W'($urandom));
				sent++;
			end
		end
	endtask

	task automatic test_random_traffic(input int snd_pct, input int rcv_pct);
		send_idle_pct = snd_pct;
		recv_idle_pct = rcv_pct;
		for (int c = 0; c < 4; c++) begin
			random_config();
			run_random_phase(160);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.lead_off = 1'b0;
		in_ch.sample = '0;
		wr_en = 1'b0;
		wr_index = ehr_pkg::REG_TICKS_PER_SAMPLE;
		wr_data = '0;
		cfg_tps = ehr_pkg::RST_TICKS_PER_SAMPLE;
		cfg_min = ehr_pkg::RST_MIN_INTERVAL_TICKS;
		cfg_timeout = ehr_pkg::RST_TIMEOUT_TICKS;
		cfg_thr = ehr_pkg::RST_CUBE_THRESHOLD;
		cfg_num = ehr_pkg::RST_RATE_NUMERATOR;
		prior_sample = '0;
		last_cube = 0;
		tick_count = '0;
		cross_stamp = '0;
		for (int i = 0; i < ehr_pkg::HIST_DEPTH; i++)
			rate_hist[i] = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_default_regs();
		test_zero_stamp_beat();
		test_rate_saturation();
		test_timeout_clear();
		test_threshold_extremes();
		test_unknown_index();
		test_random_traffic(35, 83);
		test_random_traffic(83, 35);
		test_random_traffic(0, 0);

		drain_block();
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
